[rtl/assert_macros.svh]
// Assertion macros for the checker of the stall and pause monitor.
// Both sample on clk; the first is gated off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TSPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tspm checker: property failed");

// Checked at every edge, reset included.
`define TSPM_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tspm checker: property failed");

`endif

[rtl/tspm_pkg.sv]
// Shared types, constants and helpers of the thread stall and pause monitor.
// No dependencies.
package tspm_pkg;

  // Time width (32..64) and stored depth width (8..32).
  localparam int TIME_BITS  = 64;
  localparam int DEPTH_BITS = 16;

  // Fixed port field widths.
  localparam int THR_BITS   = 40;
  localparam int CNT_BITS   = 64;
  localparam int FTIME_BITS = 64;
  localparam int IN_W       = 96;
  localparam int USER_W     = 3;
  localparam int OUT_W      = 456;

  // APB register map.
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 64;
  localparam logic REG_STALL_THR = 1'b0;  // paddr[3] of the threshold register

  localparam logic [THR_BITS-1:0] THRESH_RESET = THR_BITS'(64'd3 * 64'd1000000000);

  // Widest of time and threshold, for the stall compare.
  localparam int CMP_BITS = (TIME_BITS > THR_BITS) ? TIME_BITS : THR_BITS;

  localparam longint DEPTH_MAX_L = (longint'(1) << (DEPTH_BITS - 1)) - 1;
  localparam logic signed [32:0] DEPTH_MAX_W = 33'(DEPTH_MAX_L);
  localparam logic signed [32:0] DEPTH_MIN_W = -DEPTH_MAX_W - 33'sd1;

  typedef enum logic [2:0] {
    CMD_WAIT_BEGIN = 3'd0,
    CMD_WAIT_END   = 3'd1,
    CMD_GC_BEGIN   = 3'd2,
    CMD_GC_END     = 3'd3,
    CMD_QUERY      = 3'd4,
    CMD_START      = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [TIME_BITS-1:0] now;
    logic signed [15:0]   nest_depth;
    logic signed [7:0]    loop_level;
    logic signed [7:0]    prompt_level;
  } event_t;

  // Packed so that the last field sits in the low bits of m_tdata.
  typedef struct packed {
    logic [3:0]            pad;
    logic [FTIME_BITS-1:0] pause_max_ns;
    logic [FTIME_BITS-1:0] pause_last_ns;
    logic [FTIME_BITS-1:0] pause_total_ns;
    logic [CNT_BITS-1:0]   pause_count;
    logic                  pause_active;
    logic [CNT_BITS-1:0]   checkpoint_count;
    logic [FTIME_BITS-1:0] nested_wait_age_ns;
    logic                  nested_wait;
    logic                  waiting_for_input;
    logic                  stalled;
    logic [FTIME_BITS-1:0] checkpoint_age_ns;
  } result_t;

  // Clamp a 16-bit depth into the stored signed range.
  function automatic logic signed [DEPTH_BITS-1:0] sat_depth(logic signed [15:0] d);
    logic signed [32:0] w;
    logic signed [32:0] c;
    w = 33'(d);
    if (w > DEPTH_MAX_W) begin
      c = DEPTH_MAX_W;
    end else if (w < DEPTH_MIN_W) begin
      c = DEPTH_MIN_W;
    end else begin
      c = w;
    end
    return DEPTH_BITS'(c);
  endfunction

endpackage

[rtl/thread_stall_and_pause_monitor_unit.sv]
// Thread stall and pause monitor. Every event transfer on the s_ side yields
// exactly one result transfer on the m_ side, in order, describing the state
// after that event: checkpoint age and stall flag against stall_threshold_ns,
// responsive/nested wait status and nested-wait age, checkpoint count, and
// GC pause count, total, last and max. Throughput is one event per clock while
// m_tready does not hold the result register; each event passes the input
// register, then the result register, which drives m_tvalid. The state update
// and the result are built combinationally between those two registers.
// The threshold is written over APB
// at byte address 0 (64-bit data, low 40 bits used) and should only be
// changed while no events are in flight. Depth is clamped into DEPTH_BITS.
// Depends on tspm_pkg, tspm_cfg and tspm_core.
module thread_stall_and_pause_monitor_unit import tspm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // event stream
  input  logic              s_tvalid,
  output logic              s_tready,
  // now_ns[63:0], eval_depth[79:64], loop_level[87:80], prompt_level[95:88]
  input  logic [IN_W-1:0]   s_tdata,
  // cmd[2:0]
  input  logic [USER_W-1:0] s_tuser,
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // checkpoint_age_ns[63:0], stalled[64], waiting_for_input[65],
  // nested_wait[66], nested_wait_age_ns[130:67], checkpoint_count[194:131],
  // pause_active[195], pause_count[259:196], pause_total_ns[323:260],
  // pause_last_ns[387:324], pause_max_ns[451:388], zero pad[455:452]
  output logic [OUT_W-1:0]  m_tdata,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [THR_BITS-1:0] stall_thr;

  // input register
  logic   in_valid;
  event_t in_ev;

  // result register
  logic    out_valid;
  result_t out_res;
  result_t core_res;

  logic adv;       // result register can take a new value
  logic core_en;   // the held event is processed this cycle

  tspm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .stall_thr (stall_thr)
  );

  assign adv      = !out_valid || m_tready;
  assign s_tready = !in_valid || adv;
  assign core_en  = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ev.cmd          <= s_tuser[2:0];
      in_ev.now          <= TIME_BITS'(s_tdata[63:0]);
      in_ev.nest_depth   <= s_tdata[79:64];
      in_ev.loop_level   <= s_tdata[87:80];
      in_ev.prompt_level <= s_tdata[95:88];
    end
  end

  tspm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (core_en),
    .ev        (in_ev),
    .stall_thr (stall_thr),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_en) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;

endmodule

[rtl/tspm_cfg.sv]
// APB register file of the stall monitor: holds the stall threshold.
// Depends on tspm_pkg.
module tspm_cfg import tspm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic [THR_BITS-1:0] stall_thr
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[3] == REG_STALL_THR);

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_thr <= THRESH_RESET;
    end else if (wr_en) begin
      stall_thr <= pwdata[THR_BITS-1:0];
    end
  end

  assign prdata = (paddr[3] == REG_STALL_THR) ? APB_DW'(stall_thr) : '0;

endmodule

[rtl/tspm_core.sv]
// Watchdog and pause state of the monitor, with the per-event result logic.
// Depends on tspm_pkg. State advances on en; res reflects the state after ev.
module tspm_core import tspm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  event_t              ev,
  input  logic [THR_BITS-1:0] stall_thr,
  output result_t             res
);

  logic signed [DEPTH_BITS-1:0] least_wait_depth, least_wait_depth_next;
  logic [TIME_BITS-1:0]         checkpoint_time, checkpoint_time_next;
  logic [CNT_BITS-1:0]          checkpoints, checkpoints_next;
  logic                         awaiting_input, awaiting_input_next;
  logic                         in_nested_wait, in_nested_wait_next;
  logic [TIME_BITS-1:0]         nested_start_time, nested_start_time_next;
  logic [TIME_BITS-1:0]         pause_start_time, pause_start_time_next;
  logic                         pausing, pausing_next;
  logic [CNT_BITS-1:0]          pauses, pauses_next;
  logic [TIME_BITS-1:0]         pause_sum, pause_sum_next;
  logic [TIME_BITS-1:0]         pause_latest, pause_latest_next;
  logic [TIME_BITS-1:0]         pause_longest, pause_longest_next;

  logic signed [DEPTH_BITS-1:0] depth;
  logic                         nested;
  logic [TIME_BITS:0]           pause_diff;
  logic [TIME_BITS-1:0]         pause_el;
  logic [TIME_BITS:0]           cp_diff;
  logic [TIME_BITS:0]           nest_diff;
  logic [TIME_BITS-1:0]         age;
  logic [TIME_BITS-1:0]         nage;

  assign depth      = sat_depth(ev.nest_depth);
  assign pause_diff = {1'b0, ev.now} - {1'b0, pause_start_time};
  assign pause_el   = pause_diff[TIME_BITS] ? '0 : pause_diff[TIME_BITS-1:0];

  // Next state
  always_comb begin
    least_wait_depth_next  = least_wait_depth;
    checkpoint_time_next   = checkpoint_time;
    checkpoints_next       = checkpoints;
    awaiting_input_next    = awaiting_input;
    in_nested_wait_next    = in_nested_wait;
    nested_start_time_next = nested_start_time;
    pause_start_time_next  = pause_start_time;
    pausing_next           = pausing;
    pauses_next            = pauses;
    pause_sum_next         = pause_sum;
    pause_latest_next      = pause_latest;
    pause_longest_next     = pause_longest;
    nested                 = 1'b0;
    case (ev.cmd)
      CMD_WAIT_BEGIN: begin
        if (depth < least_wait_depth) begin
          least_wait_depth_next = depth;
        end
        // depth > new least depth is the same as depth > old least depth
        nested = (depth > least_wait_depth)
              || (!ev.loop_level[7] && (|ev.loop_level))
              || (!ev.prompt_level[7] && (|ev.prompt_level));
        if (nested) begin
          if (!in_nested_wait) begin
            nested_start_time_next = ev.now;
          end
          in_nested_wait_next = 1'b1;
        end else begin
          checkpoint_time_next   = ev.now;
          checkpoints_next       = checkpoints + 1'b1;
          in_nested_wait_next    = 1'b0;
          nested_start_time_next = '0;
        end
        awaiting_input_next = !nested;
      end
      CMD_WAIT_END: begin
        if (awaiting_input) begin
          checkpoint_time_next = ev.now;
          checkpoints_next     = checkpoints + 1'b1;
        end
        awaiting_input_next = 1'b0;
      end
      CMD_GC_BEGIN: begin
        pause_start_time_next = ev.now;
        pausing_next          = 1'b1;
      end
      CMD_GC_END: begin
        pauses_next       = pauses + 1'b1;
        pause_sum_next    = pause_sum + pause_el;
        pause_latest_next = pause_el;
        if (pause_el > pause_longest) begin
          pause_longest_next = pause_el;
        end
        pausing_next = 1'b0;
      end
      CMD_START: begin
        checkpoint_time_next = ev.now;
        checkpoints_next     = checkpoints + 1'b1;
        awaiting_input_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result from the post-event state
  assign cp_diff   = {1'b0, ev.now} - {1'b0, checkpoint_time_next};
  assign nest_diff = {1'b0, ev.now} - {1'b0, nested_start_time_next};

  always_comb begin
    age  = (awaiting_input_next || cp_diff[TIME_BITS]) ? '0 : cp_diff[TIME_BITS-1:0];
    nage = (in_nested_wait_next && !nest_diff[TIME_BITS]) ? nest_diff[TIME_BITS-1:0] : '0;
    res                    = '0;
    res.checkpoint_age_ns  = FTIME_BITS'(age);
    res.stalled            = (CMP_BITS'(age) >= CMP_BITS'(stall_thr));
    res.waiting_for_input  = awaiting_input_next;
    res.nested_wait        = in_nested_wait_next;
    res.nested_wait_age_ns = FTIME_BITS'(nage);
    res.checkpoint_count   = checkpoints_next;
    res.pause_active       = pausing_next;
    res.pause_count        = pauses_next;
    res.pause_total_ns     = FTIME_BITS'(pause_sum_next);
    res.pause_last_ns      = FTIME_BITS'(pause_latest_next);
    res.pause_max_ns       = FTIME_BITS'(pause_longest_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least_wait_depth  <= DEPTH_BITS'(DEPTH_MAX_W);
      checkpoint_time   <= '0;
      checkpoints       <= '0;
      awaiting_input    <= 1'b0;
      in_nested_wait    <= 1'b0;
      nested_start_time <= '0;
      pause_start_time  <= '0;
      pausing           <= 1'b0;
      pauses            <= '0;
      pause_sum         <= '0;
      pause_latest      <= '0;
      pause_longest     <= '0;
    end else if (en) begin
      least_wait_depth  <= least_wait_depth_next;
      checkpoint_time   <= checkpoint_time_next;
      checkpoints       <= checkpoints_next;
      awaiting_input    <= awaiting_input_next;
      in_nested_wait    <= in_nested_wait_next;
      nested_start_time <= nested_start_time_next;
      pause_start_time  <= pause_start_time_next;
      pausing           <= pausing_next;
      pauses            <= pauses_next;
      pause_sum         <= pause_sum_next;
      pause_latest      <= pause_latest_next;
      pause_longest     <= pause_longest_next;
    end
  end

endmodule

[rtl/tspm_checker.sv]
// Port-level checks for the thread stall and pause monitor, bound to the top.
// Depends on tspm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tspm_checker import tspm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  result_t r;

  assign r = result_t'(m_tdata);

  // no result is left over from before a reset
  `TSPM_ASSERT_ANY(a_rst_clears_out, rst |=> !m_tvalid)
  // a stalled result holds
  `TSPM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // a wait is either responsive or nested, never both
  `TSPM_ASSERT(a_wait_kind, m_tvalid |-> !(r.waiting_for_input && r.nested_wait))
  // a responsive wait keeps the checkpoint age at zero
  `TSPM_ASSERT(a_wait_age, m_tvalid && r.waiting_for_input |-> r.checkpoint_age_ns == '0)
  // the longest pause is never shorter than the latest one
  `TSPM_ASSERT(a_pause_max, m_tvalid |-> r.pause_max_ns >= r.pause_last_ns)

endmodule

bind thread_stall_and_pause_monitor_unit tspm_checker u_tspm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
